>>> rtl/core/stmg_pkg.sv
package stmg_pkg;

   // Widths of the item fields and the register.
   localparam int ANGLE_W = 18;
   localparam int DUR_W   = 32;
   localparam int SPD_W   = 16;
   localparam int STAT_W  = 3;

   // Step count width and the shortest half period in ticks.
   localparam int COUNT_BITS      = 24;
   localparam int MIN_HALF_PERIOD = 150;

   // Reset value of steps_per_degree (9.0 in Q8.8).
   localparam logic [SPD_W-1:0] SPD_RESET = 16'd2304;

   // Count arithmetic: magnitude times Q8.8 gain, then round and drop 16 fraction bits.
   localparam int MAG_W  = ANGLE_W;
   localparam int PROD_W = MAG_W + SPD_W;
   localparam int RND_W  = PROD_W + 1;
   localparam int FRAC_W = 16;
   localparam int CNT_HI_W = RND_W - FRAC_W;
   localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_W - 1);
   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

   // Divider widths: the divisor is twice the count.
   localparam int DIV_W  = COUNT_BITS + 1;
   localparam int ITER_W = $clog2(DUR_W + 1);

   // Command queue between front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_NONE     = 3'd0,
      ST_ACCEPTED = 3'd1,
      ST_INVALID  = 3'd2,
      ST_BUSY     = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   // Back end sequencer states.
   typedef enum logic {
      BK_IDLE,
      BK_DIV
   } back_state_type;

   // A classified item as it waits in the queue.
   typedef struct packed {
      logic                  action;
      logic                  dir;
      logic [COUNT_BITS-1:0] count;
      logic [DUR_W-1:0]      dur;
   } cmd_type;

   // Divider request and response.
   typedef struct packed {
      logic             start;
      logic [DUR_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DUR_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/stmg_queue.sv
module stmg_queue
   import stmg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   // Status flags and guarded handshakes.
   assign full     = (fill_ff == Q_CNT_W'(Q_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/stmg_front.sv
module stmg_front
   import stmg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_action,
   input  logic signed [ANGLE_W-1:0] req_angle_q8,
   input  logic [DUR_W-1:0]          req_duration_us,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SPD_W-1:0]          csr_steps_per_degree,
   input  logic                      q_full,
   output logic                      q_push,
   output cmd_type                   q_data
);

   logic [SPD_W-1:0]  spd_ff;
   logic              s0_vld_ff, s0_vld_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              accept;

   logic              action0_ff, dir0_ff;
   logic [MAG_W-1:0]  mag0_ff;
   logic [DUR_W-1:0]  dur0_ff;
   logic              action1_ff, dir1_ff;
   logic [PROD_W-1:0] prod1_ff;
   logic [DUR_W-1:0]  dur1_ff;

   logic              neg;
   logic [MAG_W-1:0]  mag;
   logic [RND_W-1:0]  rnd;
   logic [CNT_HI_W-1:0] rnd_hi;
   logic [COUNT_BITS-1:0] count;

   // One item in the front at a time; the register write is always taken.
   assign req_full  = s0_vld_ff | s1_vld_ff;
   assign accept    = req_push & ~req_full;
   assign csr_ready = 1'b1;

   // Sign and magnitude of the angle.
   assign neg = req_angle_q8[ANGLE_W-1];
   assign mag = neg ? MAG_W'(-req_angle_q8) : MAG_W'(req_angle_q8);

   // Stage valid flags: the multiply stage holds until the queue has room.
   always_comb begin
      s0_vld_in = accept;
      s1_vld_in = s0_vld_ff | (s1_vld_ff & q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_ff    <= SPD_RESET;
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            spd_ff <= csr_steps_per_degree;
         end
         s0_vld_ff <= s0_vld_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   // Capture stage: direction is 1 for a negative or zero angle.
   always_ff @(posedge clock) begin
      if (accept) begin
         action0_ff <= req_action;
         dir0_ff    <= neg | (req_angle_q8 == '0);
         mag0_ff    <= mag;
         dur0_ff    <= req_duration_us;
      end
   end

   // Multiply stage: magnitude times steps per degree.
   always_ff @(posedge clock) begin
      if (s0_vld_ff) begin
         action1_ff <= action0_ff;
         dir1_ff    <= dir0_ff;
         dur1_ff    <= dur0_ff;
         prod1_ff   <= PROD_W'(mag0_ff) * PROD_W'(spd_ff);
      end
   end

   // Round half up, drop the fraction and saturate the count.
   always_comb begin
      rnd    = RND_W'(prod1_ff) + ROUND_HALF;
      rnd_hi = rnd[RND_W-1:FRAC_W];
      if (64'(rnd_hi) > COUNT_MAX) begin
         count = COUNT_MAX[COUNT_BITS-1:0];
      end else begin
         count = COUNT_BITS'(rnd_hi);
      end
   end

   assign q_push        = s1_vld_ff & ~q_full;
   assign q_data.action = action1_ff;
   assign q_data.dir    = dir1_ff;
   assign q_data.count  = count;
   assign q_data.dur    = dur1_ff;

endmodule

>>> rtl/core/stmg_divider.sv
module stmg_divider
   import stmg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DUR_W-1:0]  quo_ff, quo_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[DUR_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(DUR_W);
         rem_in  = '0;
         dvs_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in  = {quo_ff[DUR_W-2:0], fits};
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = ~busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> rtl/core/stmg_back.sv
module stmg_back
   import stmg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmd_type           q_data,
   output logic              q_pop,
   output div_req_type       div_req,
   input  div_rsp_type       div_rsp,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_step_level,
   output logic              rsp_dir_level,
   output logic              rsp_busy_res,
   output logic [STAT_W-1:0] rsp_status
);

   back_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] steps_left_ff, steps_left_in;
   logic [DUR_W-1:0]      half_period_ff, half_period_in;
   logic [DUR_W-1:0]      tick_count_ff, tick_count_in;
   logic                  step_out_ff, step_out_in;
   logic                  dir_out_ff, dir_out_in;
   logic                  running_ff, running_in;

   logic                  out_vld_ff, out_vld_in;
   logic                  out_step_ff, out_dir_ff, out_busy_ff;
   status_type            out_stat_ff, out_stat_in;
   logic                  out_load;
   logic                  out_free;

   logic [DUR_W-1:0]      tick_next;
   logic [DUR_W-1:0]      hp_sel;

   assign out_free  = ~out_vld_ff | rsp_pop;
   assign tick_next = tick_count_ff + 1'b1;
   assign hp_sel    = (div_rsp.quotient < DUR_W'(MIN_HALF_PERIOD)) ?
                      DUR_W'(MIN_HALF_PERIOD) : div_rsp.quotient;

   // Sequencer: ticks and rejected starts finish at once, accepted starts wait
   // for the divider.
   always_comb begin
      state_in        = state_ff;
      steps_left_in   = steps_left_ff;
      half_period_in  = half_period_ff;
      tick_count_in   = tick_count_ff;
      step_out_in     = step_out_ff;
      dir_out_in      = dir_out_ff;
      running_in      = running_ff;
      out_stat_in     = ST_NONE;
      out_load        = 1'b0;
      q_pop           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = q_data.dur;
      div_req.divisor  = {q_data.count, 1'b0};

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (!q_data.action) begin
                  // One microsecond tick.
                  out_load = 1'b1;
                  if (running_ff) begin
                     if (tick_next < half_period_ff) begin
                        tick_count_in = tick_next;
                     end else begin
                        tick_count_in = '0;
                        if (step_out_ff) begin
                           step_out_in = 1'b0;
                        end else begin
                           steps_left_in = steps_left_ff - 1'b1;
                           if (steps_left_in == '0) begin
                              running_in  = 1'b0;
                              out_stat_in = ST_DONE;
                           end else begin
                              step_out_in = 1'b1;
                           end
                        end
                     end
                  end
               end else if (running_ff) begin
                  // A start while a move runs is ignored.
                  out_load    = 1'b1;
                  out_stat_in = ST_BUSY;
               end else begin
                  dir_out_in = q_data.dir;
                  if (q_data.count == '0 || q_data.dur == '0) begin
                     out_load    = 1'b1;
                     out_stat_in = ST_INVALID;
                  end else begin
                     steps_left_in = q_data.count;
                     div_req.start = 1'b1;
                     state_in      = BK_DIV;
                  end
               end
            end
         end
         BK_DIV: begin
            if (div_rsp.done && out_free) begin
               half_period_in = hp_sel;
               tick_count_in  = '0;
               step_out_in    = 1'b1;
               running_in     = 1'b1;
               out_load       = 1'b1;
               out_stat_in    = ST_ACCEPTED;
               state_in       = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Result register valid flag.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         steps_left_ff  <= '0;
         half_period_ff <= '0;
         tick_count_ff  <= '0;
         step_out_ff    <= 1'b0;
         dir_out_ff     <= 1'b0;
         running_ff     <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         steps_left_ff  <= steps_left_in;
         half_period_ff <= half_period_in;
         tick_count_ff  <= tick_count_in;
         step_out_ff    <= step_out_in;
         dir_out_ff     <= dir_out_in;
         running_ff     <= running_in;
         out_vld_ff     <= out_vld_in;
      end
   end

   // Result payload shows the state after the item.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_step_ff <= step_out_in;
         out_dir_ff  <= dir_out_in;
         out_busy_ff <= running_in;
         out_stat_ff <= out_stat_in;
      end
   end

   assign rsp_empty      = ~out_vld_ff;
   assign rsp_step_level = out_step_ff;
   assign rsp_dir_level  = out_dir_ff;
   assign rsp_busy_res   = out_busy_ff;
   assign rsp_status     = out_stat_ff;

endmodule

>>> rtl/core/stepper_timed_move_generator_top.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_push/req_full  action, angle_q8, duration_us
// rsp_      out        rsp_empty/rsp_pop  step_level, dir_level, busy_res, status
// csr_      in         csr_valid/csr_ready steps_per_degree
//
// A tick or a rejected start passes the multiply stage, the queue and the back end's result
// register in that order before its result shows; a full queue or a waiting result can hold it.
// An accepted start also waits for the bit-serial 32-bit divider that forms the half period.
// The front holds one item and takes the next once the last has entered the queue.
// Reset is synchronous and active high; it restores steps_per_degree to 9.0.
// A held result stalls the back end only; the front keeps filling the queue.
module stepper_timed_move_generator_top
   import stmg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_action,
   input  logic signed [ANGLE_W-1:0] req_angle_q8,
   input  logic [DUR_W-1:0]          req_duration_us,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_step_level,
   output logic                      rsp_dir_level,
   output logic                      rsp_busy_res,
   output logic [STAT_W-1:0]         rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SPD_W-1:0]          csr_steps_per_degree
);

   cmd_type     push_cmd, pop_cmd;
   logic        q_push, q_full, q_pop, q_empty;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Front end: captures items and works out direction and step count.
   stmg_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_action           (req_action),
      .req_angle_q8         (req_angle_q8),
      .req_duration_us      (req_duration_us),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_steps_per_degree (csr_steps_per_degree),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_data               (push_cmd)
   );

   // Short queue between the two halves.
   stmg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   // Half period divider.
   stmg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Back end: runs the pulse train and produces results.
   stmg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (pop_cmd),
      .q_pop          (q_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_step_level (rsp_step_level),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_status     (rsp_status)
   );

endmodule

>>> rtl/core/stmg_checker.sv
module stmg_checker
   import stmg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic              rsp_step_level,
   input logic              rsp_busy_res,
   input logic [STAT_W-1:0] rsp_status
);

   // A finished move leaves the step line low and the generator idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_DONE) |-> (!rsp_busy_res && !rsp_step_level))
      else $error("move complete result shows a running pulse train");

   // An accepted start begins with the step line high.
   a_accept_high: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_ACCEPTED) |-> (rsp_busy_res && rsp_step_level))
      else $error("accepted start result does not show a running high step");

   // A start is ignored only while a move runs, and rejected only while idle.
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == ST_BUSY || rsp_status == ST_INVALID)) |->
      (rsp_busy_res == (rsp_status == ST_BUSY)))
      else $error("busy or invalid status disagrees with busy_res");

   // The step line is never high while no move runs.
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_busy_res) |-> !rsp_step_level)
      else $error("step line high while idle");

   // A waiting result stays until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_status)))
      else $error("waiting result changed before it was taken");

endmodule

bind stepper_timed_move_generator_top stmg_checker u_stmg_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_step_level (rsp_step_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_status     (rsp_status)
);
